// File: hw/rtl/grd_pkg.sv
// Shared types and constants of the gamepad report decoder.
`default_nettype none

package grd_pkg;

    localparam int AXIS_W   = 8;
    localparam int NUM_AXES = 6;
    localparam int POS_W    = 6;
    localparam int BTN_W    = 16;
    localparam int TOUCH_W  = 25;
    localparam int FLAG_W   = BTN_W + 2;

    // lx, ly, rx, ry, lt, rt from index 0
    typedef logic [NUM_AXES-1:0][AXIS_W-1:0] t_axes;
    typedef logic [FLAG_W-1:0]               t_flags;
    typedef logic [1:0]                      t_layout;

    localparam t_layout LAYOUT_NONE     = 2'd0;
    localparam t_layout LAYOUT_SIMPLE   = 2'd1;
    localparam t_layout LAYOUT_EXTENDED = 2'd2;

    localparam logic [7:0] ID_SIMPLE   = 8'h01;
    localparam logic [7:0] ID_EXTENDED = 8'h31;

    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // simple layout byte positions
    localparam logic [POS_W-1:0] S_POS_HAT      = 6'd5;
    localparam logic [POS_W-1:0] S_POS_SHOULDER = 6'd6;
    localparam logic [POS_W-1:0] S_POS_SYSTEM   = 6'd7;
    localparam logic [POS_W-1:0] S_POS_LTRIG    = 6'd8;
    localparam logic [POS_W-1:0] S_POS_RTRIG    = 6'd9;

    // extended layout byte positions
    localparam logic [POS_W-1:0] E_POS_HAT      = 6'd8;
    localparam logic [POS_W-1:0] E_POS_SHOULDER = 6'd9;
    localparam logic [POS_W-1:0] E_POS_SYSTEM   = 6'd10;
    localparam logic [POS_W-1:0] E_POS_TOUCH1   = 6'd33;
    localparam logic [POS_W-1:0] E_POS_TOUCH2   = 6'd37;

    localparam logic [2:0] AXIS_LTRIG = 3'd4;
    localparam logic [2:0] AXIS_RTRIG = 3'd5;

    localparam logic [0:0] REG_DEADZONE = 1'b0;

endpackage

`default_nettype wire

// File: hw/rtl/grd_change_det.sv
// Change detector: compares live state against the previous report's snapshot.
`default_nettype none

module grd_change_det
    import grd_pkg::*;
(
    input  wire t_axes       i_live_axes,
    input  wire t_axes       i_prior_axes,
    input  wire t_flags      i_live_flags,
    input  wire t_flags      i_prior_flags,
    input  wire [AXIS_W-1:0] i_deadzone,
    output logic             o_changed
);

    logic [NUM_AXES-1:0] axis_moved;

    // one subtract and compare per axis, all in parallel
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (i_live_axes[k] > i_prior_axes[k]) begin
                axis_moved[k] = (i_live_axes[k] - i_prior_axes[k]) > i_deadzone;
            end else begin
                axis_moved[k] = (i_prior_axes[k] - i_live_axes[k]) > i_deadzone;
            end
        end
    end

    assign o_changed = (i_live_flags != i_prior_flags) || (|axis_moved);

endmodule

`default_nettype wire

// File: hw/rtl/gamepad_report_decoder.sv
// Gamepad input report decoder top level: byte stream in, decoded state out.
//
// Usage:
//   Report bytes enter on the s_axis channel, one byte per request, tlast on
//   the final byte. Byte 0 is the report identifier (0x01 simple, 0x31
//   extended); later bytes are written by position into the live state.
//   On the last byte one result leaves on the m_axis channel: buttons, sticks,
//   triggers and two touch points in tdata, report_ok and state_changed in
//   tuser. Bytes without tlast produce nothing on the output.
//   The APB port holds the jitter deadzone (address 0, reset value 2); write
//   it only while no report is in flight.
// Throughput and pipeline:
//   One byte per cycle, sustained while no final byte waits on the result
//   register. A byte is captured in the input register, then decoded into
//   the live state and (on tlast) into the result register. The decode step
//   is a position-indexed field write plus six parallel deadzone compares.
// Reset:
//   Synchronous, active low. Clears the byte position, layout, live state,
//   prior snapshot and both valid flags; the deadzone returns to 2.
// Backpressure:
//   While a result waits in the output register, non-final bytes keep
//   flowing; a second final byte holds in the input register until the
//   waiting result is taken, and s_axis_tready is low while it holds.
`default_nettype none

module gamepad_report_decoder
    import grd_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,

    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire          i_s_axis_tlast,   // last_byte

    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [15:0] button_bits, [23:16] left_x, [31:24] left_y, [39:32] right_x,
    // [47:40] right_y, [55:48] left_trig, [63:56] right_trig,
    // [88:64] touch_one, [113:89] touch_two, [119:114] zero
    output logic [119:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // [0] report_ok, [1] state_changed

    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int PAD_W = 120 - BTN_W - NUM_AXES * AXIS_W - 2 * TOUCH_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [AXIS_W-1:0] r_deadzone;
    logic              cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2:2] == REG_DEADZONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= 8'd2;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_deadzone <= pwdata[AXIS_W-1:0];
        end
    end

    // paddr[1:0] is the byte lane inside the word and is not decoded
    assign prdata = cfg_hit ? {{(32 - AXIS_W){1'b0}}, r_deadzone} : 32'd0;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       advance;   // input register drains into the decode step
    logic       in_accept;

    // a final byte needs the result register free or draining
    assign advance   = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_pos,    n_pos;
    t_layout            r_layout, n_layout;
    t_layout            layout_eff;
    t_axes              r_axes,   n_axes;
    logic [BTN_W-1:0]   r_btn,    n_btn;
    logic [TOUCH_W-1:0] r_t1,     n_t1;
    logic [TOUCH_W-1:0] r_t2,     n_t2;
    t_axes              r_prior_axes;
    t_flags             r_prior_flags;
    t_flags             live_flags;
    logic [3:0]         hat_dirs;
    logic [2:0]         axis_idx;
    logic               pos_in_range;
    logic [3:0]         hat;

    assign hat          = r_in_byte[3:0];
    assign axis_idx     = 3'(r_pos - 6'd1);
    assign pos_in_range = ({1'b0, r_pos} < 7'(MAX_REPORT_BYTES));

    // hat switch: 0..7 clockwise from up, 8..15 centered
    assign hat_dirs[0] = (hat == 4'd0) || (hat == 4'd1) || (hat == 4'd7);
    assign hat_dirs[1] = (hat == 4'd1) || (hat == 4'd2) || (hat == 4'd3);
    assign hat_dirs[2] = (hat == 4'd3) || (hat == 4'd4) || (hat == 4'd5);
    assign hat_dirs[3] = (hat == 4'd5) || (hat == 4'd6) || (hat == 4'd7);

    // layout that governs this byte; byte 0 picks it
    always_comb begin
        if (r_pos == '0) begin
            if (r_in_byte == ID_SIMPLE) begin
                layout_eff = LAYOUT_SIMPLE;
            end else if (r_in_byte == ID_EXTENDED) begin
                layout_eff = LAYOUT_EXTENDED;
            end else begin
                layout_eff = LAYOUT_NONE;
            end
        end else begin
            layout_eff = r_layout;
        end
    end

    // write the byte into its field by position
    always_comb begin
        n_axes = r_axes;
        n_btn  = r_btn;
        n_t1   = r_t1;
        n_t2   = r_t2;
        if (r_pos != '0 && pos_in_range) begin
            if (r_layout == LAYOUT_SIMPLE) begin
                case (r_pos) inside
                    [6'd1:6'd4]:    n_axes[axis_idx] = r_in_byte;
                    S_POS_HAT:      n_btn[7:0]   = {r_in_byte[7:4], hat_dirs};
                    S_POS_SHOULDER: n_btn[13:8]  = {r_in_byte[7:4], r_in_byte[1:0]};
                    S_POS_SYSTEM:   n_btn[15:14] = r_in_byte[1:0];
                    S_POS_LTRIG:    n_axes[AXIS_LTRIG] = r_in_byte;
                    S_POS_RTRIG:    n_axes[AXIS_RTRIG] = r_in_byte;
                    default: ;
                endcase
            end else if (r_layout == LAYOUT_EXTENDED) begin
                case (r_pos) inside
                    [6'd1:6'd6]:    n_axes[axis_idx] = r_in_byte;
                    E_POS_HAT:      n_btn[7:0]   = {r_in_byte[7:4], hat_dirs};
                    E_POS_SHOULDER: n_btn[13:8]  = {r_in_byte[7:4], r_in_byte[1:0]};
                    E_POS_SYSTEM:   n_btn[15:14] = r_in_byte[1:0];
                    // touch head: bit 7 clear means touching
                    E_POS_TOUCH1:   n_t1[24] = ~r_in_byte[7];
                    E_POS_TOUCH1 + 6'd1: if (r_t1[24]) n_t1[7:0]   = r_in_byte;
                    E_POS_TOUCH1 + 6'd2: if (r_t1[24]) n_t1[15:8]  = r_in_byte;
                    E_POS_TOUCH1 + 6'd3: if (r_t1[24]) n_t1[23:16] = r_in_byte;
                    E_POS_TOUCH2:   n_t2[24] = ~r_in_byte[7];
                    E_POS_TOUCH2 + 6'd1: if (r_t2[24]) n_t2[7:0]   = r_in_byte;
                    E_POS_TOUCH2 + 6'd2: if (r_t2[24]) n_t2[15:8]  = r_in_byte;
                    E_POS_TOUCH2 + 6'd3: if (r_t2[24]) n_t2[23:16] = r_in_byte;
                    default: ;
                endcase
            end
        end
    end

    // advance the byte counter; return to byte 0 after a final byte
    always_comb begin
        if (r_in_last) begin
            n_pos    = '0;
            n_layout = LAYOUT_NONE;
        end else begin
            n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + 6'd1;
            n_layout = layout_eff;
        end
    end

    assign live_flags = {n_t2[24], n_t1[24], n_btn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_layout      <= LAYOUT_NONE;
            r_axes        <= '0;
            r_btn         <= '0;
            r_t1          <= '0;
            r_t2          <= '0;
            r_prior_axes  <= '0;
            r_prior_flags <= '0;
        end else if (advance) begin
            r_pos    <= n_pos;
            r_layout <= n_layout;
            r_axes   <= n_axes;
            r_btn    <= n_btn;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            if (r_in_last) begin
                r_prior_axes  <= n_axes;
                r_prior_flags <= live_flags;
            end
        end
    end

    // ------------------------------------------------------------------
    // Change detection and result register
    // ------------------------------------------------------------------
    logic raw_changed;
    logic out_load;

    grd_change_det u_change_det (
        .i_live_axes   (n_axes),
        .i_prior_axes  (r_prior_axes),
        .i_live_flags  (live_flags),
        .i_prior_flags (r_prior_flags),
        .i_deadzone    (r_deadzone),
        .o_changed     (raw_changed)
    );

    assign out_load = advance && r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_m_axis_tdata    <= {{PAD_W{1'b0}}, n_t2, n_t1, n_axes, n_btn};
            o_m_axis_tuser[0] <= (layout_eff != LAYOUT_NONE);
            o_m_axis_tuser[1] <= (layout_eff != LAYOUT_NONE) && raw_changed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> (r_pos == '0) && (r_layout == LAYOUT_NONE))
        else $error("byte position not cleared after final byte");

    a_no_change_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> !o_m_axis_tuser[1])
        else $error("state_changed set on unknown report");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !out_load)
        else $error("waiting result overwritten");

    a_prior_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_prior_axes == o_m_axis_tdata[BTN_W + NUM_AXES*AXIS_W - 1:BTN_W]))
        else $error("prior snapshot differs from emitted axes");

endmodule

`default_nettype wire
